@@ rtl/ate_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ate_pkg;

  localparam int CMD_W = 2;
  localparam int POS_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W = 5;
  localparam int ST_W = 2;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                     command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] old_value;
    logic [IDX_W-1:0]         found_index;
    status_t                  status;
    logic [IDX_W-1:0]         entry_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/ate_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ate_ram #(
  parameter int DEPTH = ate_pkg::DEPTH_DEFAULT,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [ate_pkg::DATA_W-1:0]   wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [ate_pkg::DATA_W-1:0]   rdata
);
  import ate_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ate_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ate_seq #(
  parameter int DEPTH = ate_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ate_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output ate_pkg::res_t      res
);
  import ate_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_GET  = 7'b0000100,
    S_DOWN = 7'b0001000,
    S_UP   = 7'b0010000,
    S_PUT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     j;
  cmd_t              cmd_r;
  logic [CW-1:0]     pos_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] old_r;
  logic [CW-1:0]     idx_r;
  status_t           st_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [CW:0]       j_p1;
  logic [CW:0]       j_p2;
  logic [CW-1:0]     j_m1;
  logic [CW-1:0]     j_m2;
  logic [CW-1:0]     cnt_m1;
  logic              pos_lt;
  logic              pos_gt;
  logic              is_full;
  logic              hit;

  assign pos_x   = XW'(req.position);
  assign cnt_x   = XW'(count);
  assign pos_lt  = pos_x < cnt_x;
  assign pos_gt  = pos_x > cnt_x;
  assign is_full = count >= CW'(DEPTH);
  assign j_p1    = {1'b0, j} + (CW+1)'(1);
  assign j_p2    = {1'b0, j} + (CW+1)'(2);
  assign j_m1    = j - CW'(1);
  assign j_m2    = j - CW'(2);
  assign cnt_m1  = count - CW'(1);
  assign hit     = rdata == val_r;

  assign req_ready = state == S_IDLE;
  assign res_valid = state == S_DONE;

  assign res.old_value   = old_r;
  assign res.found_index = IDX_W'(idx_r);
  assign res.status      = st_r;
  assign res.entry_count = IDX_W'(count);

  ate_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = val_r;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.command)
            CMD_SEARCH: begin
              re = count != '0;
            end
            CMD_UPDATE, CMD_REMOVE: begin
              re    = pos_lt;
              raddr = pos_x[AW-1:0];
            end
            CMD_INSERT: begin
              if (!pos_gt && !is_full) begin
                if (pos_x == cnt_x) begin
                  we    = 1'b1;
                  waddr = pos_x[AW-1:0];
                  wdata = req.data_value;
                end else begin
                  re    = 1'b1;
                  raddr = cnt_m1[AW-1:0];
                end
              end
            end
            default: begin
              re = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        re    = !hit && (j_p1 < (CW+1)'(count));
        raddr = j_p1[AW-1:0];
      end
      S_GET: begin
        if (cmd_r == CMD_UPDATE) begin
          we    = 1'b1;
          waddr = j[AW-1:0];
        end else begin
          re    = j_p1 < (CW+1)'(count);
          raddr = j_p1[AW-1:0];
        end
      end
      S_DOWN: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
        re    = j_p2 < (CW+1)'(count);
        raddr = j_p2[AW-1:0];
      end
      S_UP: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
        re    = j_m1 > pos_r;
        raddr = j_m2[AW-1:0];
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = pos_r[AW-1:0];
      end
      S_DONE: begin
        re = 1'b0;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_r <= req.command;
            pos_r <= CW'(pos_x);
            val_r <= req.data_value;
            old_r <= '0;
            idx_r <= '0;
            unique case (req.command)
              CMD_SEARCH: begin
                j <= '0;
                if (count == '0) begin
                  st_r  <= ST_NOT_FOUND;
                  state <= S_DONE;
                end else begin
                  st_r  <= ST_OK;
                  state <= S_SCAN;
                end
              end
              CMD_UPDATE, CMD_REMOVE: begin
                j <= CW'(pos_x);
                if (pos_lt) begin
                  st_r  <= ST_OK;
                  state <= S_GET;
                end else begin
                  st_r  <= ST_BAD_POS;
                  state <= S_DONE;
                end
              end
              CMD_INSERT: begin
                j <= count;
                if (pos_gt) begin
                  st_r  <= ST_BAD_POS;
                  state <= S_DONE;
                end else if (is_full) begin
                  st_r  <= ST_FULL;
                  state <= S_DONE;
                end else if (pos_x == cnt_x) begin
                  st_r  <= ST_OK;
                  count <= count + CW'(1);
                  state <= S_DONE;
                end else begin
                  st_r  <= ST_OK;
                  state <= S_UP;
                end
              end
              default: begin
                j     <= '0;
                st_r  <= ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            idx_r <= j;
            state <= S_DONE;
          end else if (j_p1 >= (CW+1)'(count)) begin
            idx_r <= count;
            st_r  <= ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            j <= j_p1[CW-1:0];
          end
        end
        S_GET: begin
          old_r <= rdata;
          if (cmd_r == CMD_UPDATE) begin
            state <= S_DONE;
          end else if (j_p1 < (CW+1)'(count)) begin
            state <= S_DOWN;
          end else begin
            count <= cnt_m1;
            state <= S_DONE;
          end
        end
        S_DOWN: begin
          if (j_p2 < (CW+1)'(count)) begin
            j <= j_p1[CW-1:0];
          end else begin
            count <= cnt_m1;
            state <= S_DONE;
          end
        end
        S_UP: begin
          if (j_m1 > pos_r) begin
            j <= j_m1;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/array_table_engine.sv @@
// An insert at the end of the table, and a command that fails or searches an empty table, goes
// straight from idle to done; an update passes through the get state; a search, remove or insert
// that walks the table moves one entry per cycle through the single-port-read RAM.
// A new request is taken only while the sequencer is idle; the output register lets the next
// transaction start while a result waits. Reset clears the entry count, sequencer state and output
// valid flag; table contents are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module array_table_engine #(
  parameter int DEPTH = ate_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ate_pkg::CMD_W-1:0]          command,
  input  wire logic [ate_pkg::POS_W-1:0]          position,
  input  wire logic signed [ate_pkg::DATA_W-1:0]  data_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [ate_pkg::DATA_W-1:0]       old_value,
  output logic [ate_pkg::IDX_W-1:0]               found_index,
  output logic [ate_pkg::ST_W-1:0]                status,
  output logic [ate_pkg::IDX_W-1:0]               entry_count
);
  import ate_pkg::*;

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;

  assign req.command    = cmd_t'(command);
  assign req.position   = position;
  assign req.data_value = data_value;

  assign res_ready = !out_valid || out_ready;

  ate_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      old_value   <= res.old_value;
      found_index <= res.found_index;
      status      <= res.status;
      entry_count <= res.entry_count;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ate_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ate_checker #(
  parameter int DEPTH = ate_pkg::DEPTH_DEFAULT
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [ate_pkg::CMD_W-1:0]          command,
  input wire logic [ate_pkg::POS_W-1:0]          position,
  input wire logic signed [ate_pkg::DATA_W-1:0]  data_value,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [ate_pkg::DATA_W-1:0]  old_value,
  input wire logic [ate_pkg::IDX_W-1:0]          found_index,
  input wire logic [ate_pkg::ST_W-1:0]           status,
  input wire logic [ate_pkg::IDX_W-1:0]          entry_count
);
  import ate_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(old_value) && $stable(found_index)
      && $stable(status) && $stable(entry_count))
    else $error("Result changed while stalled.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (int'(entry_count) <= DEPTH))
    else $error("Entry count exceeds table depth.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == IDX_W'(DEPTH))
    else $error("Full status with table not full.");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_FOUND |-> found_index == entry_count)
    else $error("Miss index differs from entry count.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD_POS || status == ST_FULL)
      |-> old_value == '0 && found_index == '0)
    else $error("Failed transaction returned nonzero data.");

endmodule

bind array_table_engine ate_checker #(.DEPTH(DEPTH)) u_ate_checker (.*);

`default_nettype wire
